// ===== rtl/core/pfd_pkg.sv =====
// Shared types and constants for the Prufer sequence decoder.
`timescale 1ns / 1ps
package pfd_pkg;

  // Vertex labels on the ports and the vertex-count register width
  localparam int VERT_W = 5;
  localparam int NV_W   = 6;

  // Default vertex capacity and register reset value
  localparam int          MAX_VERTICES_DEF = 32;
  localparam logic [NV_W-1:0] NV_RESET     = 6'd32;

  // Input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Queue depths between the parts
  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  // Input beat
  typedef struct packed {
    logic              kind;
    logic [VERT_W-1:0] code;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [VERT_W-1:0] leaf_vertex;
    logic [VERT_W-1:0] joined_vertex;
    logic              last_edge;
    logic              bad_sequence;
  } out_beat_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic              is_decode;
    logic [VERT_W-1:0] code;
    logic              code_bad;
  } cmd_t;

  // Back-end status
  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// ===== rtl/core/pfd_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
module pfd_front import pfd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_beat_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t                cmd_in;
  logic                do_push;
  logic                do_pop;

  // Classify: decode vs load, and flag labels past the vertex capacity
  always_comb begin
    cmd_in.is_decode = (in_data.kind == KIND_DECODE);
    cmd_in.code      = in_data.code;
    cmd_in.code_bad  = (NV_W'(in_data.code) >= NV_W'(MAX_VERTICES));
  end

  assign full      = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? CQ_PTR_W'(wr_ptr_r + CQ_PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? CQ_PTR_W'(rd_ptr_r + CQ_PTR_W'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/pfd_back.sv =====
// Back end: code store, occurrence counts and the one-edge-per-cycle decoder, stalled while the result queue is full.
`timescale 1ns / 1ps
module pfd_back import pfd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [NV_W-1:0] cfg_num_vertices,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  output logic            res_push,
  output out_beat_t       res,
  input  logic            res_full,
  output back_status_t    st
);

  localparam int STORE_DEPTH = MAX_VERTICES - 2;
  localparam int CNT_W       = $clog2(MAX_VERTICES);
  localparam int VIDX_W      = $clog2(MAX_VERTICES);
  localparam int AW          = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
  localparam int MEM_DEPTH   = 1 << AW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BUILD = 4'b0010,
    S_STEP  = 4'b0100,
    S_LAST  = 4'b1000
  } bstate_t;

  bstate_t                  state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     err_r, err_nxt;
  logic [VIDX_W-1:0]        maxc_r, maxc_nxt;
  logic [MAX_VERTICES-1:0]  leaf_r, leaf_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [NV_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]         occ_r [MAX_VERTICES];

  logic [VIDX_W-1:0]        mem [MEM_DEPTH];
  logic [VIDX_W-1:0]        rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  logic                     occ_we;
  logic [VIDX_W-1:0]        occ_widx;
  logic [CNT_W-1:0]         occ_wval;
  logic                     clear;

  logic [NV_W-1:0]          n_clamp;
  logic [NV_W-1:0]          m_val;
  logic                     is_bad;
  logic [MAX_VERTICES-1:0]  zmask;
  logic [VIDX_W-1:0]        lo_idx;
  logic [VIDX_W-1:0]        hi_idx;
  logic [VIDX_W-1:0]        ld_idx;
  logic [CNT_W-1:0]         occ_dec;
  logic                     room;

  assign st.busy = (state_r != S_IDLE);
  assign room    = !res_full;

  // Vertex count clamped to the supported range
  always_comb begin
    if (cfg_num_vertices < NV_W'(2)) begin
      n_clamp = NV_W'(2);
    end else if (cfg_num_vertices > NV_W'(MAX_VERTICES)) begin
      n_clamp = NV_W'(MAX_VERTICES);
    end else begin
      n_clamp = cfg_num_vertices;
    end
  end

  // Sequence check against the latched vertex count
  assign m_val  = n_r - NV_W'(2);
  assign is_bad = err_r || (NV_W'(cnt_r) != m_val) || (NV_W'(maxc_r) >= n_r);

  // Initial leaves: in-range vertices that never occur in the sequence
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      zmask[i] = (occ_r[i] == '0) && (NV_W'(i) < n_r);
    end
  end

  // Lowest and highest leaf
  always_comb begin
    lo_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (leaf_r[i]) begin
        lo_idx = VIDX_W'(i);
      end
    end
  end

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (leaf_r[i]) begin
        hi_idx = VIDX_W'(i);
      end
    end
  end

  assign ld_idx  = cmd.code[VIDX_W-1:0];
  assign occ_dec = occ_r[rd_data_r] - CNT_W'(1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    maxc_nxt  = maxc_r;
    leaf_nxt  = leaf_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    occ_we    = 1'b0;
    occ_widx  = ld_idx;
    occ_wval  = '0;
    clear     = 1'b0;
    rd_addr   = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_decode) begin
            n_nxt     = n_clamp;
            state_nxt = S_BUILD;
          end else if (cmd.code_bad || (cnt_r >= CNT_W'(STORE_DEPTH))) begin
            err_nxt = 1'b1;
          end else begin
            mem_we   = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
            occ_we   = 1'b1;
            occ_widx = ld_idx;
            occ_wval = occ_r[ld_idx] + CNT_W'(1);
            if (ld_idx > maxc_r) begin
              maxc_nxt = ld_idx;
            end
          end
        end
      end

      S_BUILD: begin
        rd_addr = '0;
        if (room) begin
          if (is_bad) begin
            res_push           = 1'b1;
            res.last_edge      = 1'b1;
            res.bad_sequence   = 1'b1;
            clear              = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            leaf_nxt  = zmask;
            idx_nxt   = '0;
            state_nxt = (m_val == '0) ? S_LAST : S_STEP;
          end
        end
      end

      S_STEP: begin
        if (room) begin
          res_push          = 1'b1;
          res.leaf_vertex   = VERT_W'(lo_idx);
          res.joined_vertex = VERT_W'(rd_data_r);
          occ_we            = 1'b1;
          occ_widx          = rd_data_r;
          occ_wval          = occ_dec;
          // retire the leaf; the code joins the leaves once its count hits zero
          leaf_nxt = leaf_r & ~(MAX_VERTICES'(1) << lo_idx);
          if (occ_dec == '0) begin
            leaf_nxt = leaf_nxt | (MAX_VERTICES'(1) << rd_data_r);
          end
          idx_nxt = idx_r + CNT_W'(1);
          rd_addr = idx_nxt[AW-1:0];
          if (NV_W'(idx_nxt) == m_val) begin
            state_nxt = S_LAST;
          end
        end
      end

      S_LAST: begin
        if (room) begin
          // exactly two leaves remain here
          res_push          = 1'b1;
          res.leaf_vertex   = VERT_W'(lo_idx);
          res.joined_vertex = VERT_W'(hi_idx);
          res.last_edge     = 1'b1;
          clear             = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clear) begin
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
      maxc_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      maxc_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      maxc_r  <= maxc_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    leaf_r <= leaf_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
  end

  // Occurrence counts, cleared by reset and at the end of every decode
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        occ_r[i] <= '0;
      end
    end else if (occ_we) begin
      occ_r[occ_widx] <= occ_wval;
    end
  end

  // Code store: written at the fill count, read one step ahead
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= ld_idx;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/pfd_out_fifo.sv =====
// Result queue between the decoder and the output port.
`timescale 1ns / 1ps
module pfd_out_fifo import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_beat_t wr_data,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_beat_t rd_data
);

  localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  out_beat_t           q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = q_r[rd_ptr_r];
  assign do_push = wr_en && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? OQ_PTR_W'(wr_ptr_r + OQ_PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? OQ_PTR_W'(rd_ptr_r + OQ_PTR_W'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + OQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/prufer_sequence_decoder.sv =====
// Top level of the Prufer sequence decoder: config register, front, back, result queue.
//
//   channel   ports                      beat type    accepted when
//   input     push, full, in_data        in_beat_t    push && !full
//   result    empty, pop, out_data       out_beat_t   pop && !empty
//   config    cfg_we, cfg_wdata          6-bit value  cfg_we
//
// A load beat is taken by the idle back end; loads stream at one per cycle while it is idle.
// A decode beat passes an issue step and a check step; the single engine then emits the
// tree's edges on n vertices, one per cycle unless stalled; a rejected sequence yields only
// the bad-sequence beat from the check step. Loads queued behind a decode wait.
// Synchronous active-low reset clears the counts, queues and register (n = 32).
// A full result queue stalls the decoder; a full command queue raises full.
`timescale 1ns / 1ps
module prufer_sequence_decoder import pfd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [NV_W-1:0] cfg_wdata,
  input  logic            push,
  output logic            full,
  input  in_beat_t        in_data,
  output logic            empty,
  input  logic            pop,
  output out_beat_t       out_data
);

  logic [NV_W-1:0] num_vertices_r;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_pop;
  logic            res_push;
  out_beat_t       res;
  logic            res_full;
  back_status_t    st;

  // Vertex-count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= NV_RESET;
    end else if (cfg_we) begin
      num_vertices_r <= cfg_wdata;
    end
  end

  pfd_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  pfd_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_num_vertices(num_vertices_r),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .res_push        (res_push),
    .res             (res),
    .res_full        (res_full),
    .st              (st)
  );

  pfd_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .empty  (empty),
    .pop    (pop),
    .rd_data(out_data)
  );

`ifndef SYNTH
  // Decoder never writes a full result queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // Back end only takes commands that are there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // The closing beat of a decode returns the back end to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last_edge) |=> !st.busy)
    else $error("decoder busy after last edge");

  // No results while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !st.busy |-> !res_push)
    else $error("result pushed while idle");
`endif

endmodule

// ===== verif/prufer_sequence_decoder_test.sv =====
// Self-checking testbench for the Prufer sequence decoder: queue-driven stimulus and scoreboard.
`timescale 1ns / 1ps
module prufer_sequence_decoder_test;
  import pfd_pkg::*;

  localparam int STORE_DEPTH    = MAX_VERTICES_DEF - 2;
  localparam int TARGET_BEATS   = 470;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT       = 13;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [NV_W-1:0] cfg_wdata = '0;
  logic            push      = 1'b0;
  logic            full;
  in_beat_t        in_data   = '0;
  logic            empty;
  logic            pop       = 1'b0;
  out_beat_t       out_data;

  prufer_sequence_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  // Clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Beats waiting to be driven and edges waiting to come out
  in_beat_t  beat_queue [$];
  out_beat_t edge_queue [$];

  // Shadow of the decoder state
  int              nv_now = int'(NV_RESET);
  logic [VERT_W-1:0] seq_code [STORE_DEPTH];
  logic [VERT_W-1:0] seq_occ [MAX_VERTICES_DEF];
  int              seq_len = 0;
  logic            seq_err = 1'b0;

  // Bookkeeping
  int  err_cnt      = 0;
  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  load_cnt     = 0;
  int  decode_cnt   = 0;
  int  reject_cnt   = 0;
  int  edge_cnt     = 0;
  int  cfg_cnt      = 0;
  int  idle_cycles  = 0;

  // Handshake helpers
  logic in_fired  = 1'b0;
  int   in_gap    = 0;
  logic in_calm   = 1'b0;
  logic out_fired = 1'b0;
  int   out_stall = 0;
  logic out_calm  = 1'b1;

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int effective_n(input logic [NV_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return int'(v);
  endfunction

  // Lowest set bit, vertex 0 when the set is empty
  function automatic logic [VERT_W-1:0] lowest_leaf(input logic [31:0] leaves);
    for (int i = 0; i < 32; i++)
      if (leaves[i]) return i[VERT_W-1:0];
    return '0;
  endfunction

  function automatic int draw_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic clear_sequence();
    seq_len = 0;
    seq_err = 1'b0;
    for (int i = 0; i < MAX_VERTICES_DEF; i++) seq_occ[i] = '0;
  endtask

  // Apply one accepted beat to the shadow state; queue the edges it yields
  task automatic decode_beat(input in_beat_t b);
    int                n;
    int                m;
    logic              bad;
    logic [31:0]       leaves;
    logic [VERT_W-1:0] v;
    logic [VERT_W-1:0] u;
    logic [VERT_W-1:0] w;
    out_beat_t         e;
    if (b.kind == KIND_LOAD) begin
      load_cnt++;
      if (seq_len >= STORE_DEPTH) begin
        seq_err = 1'b1;
      end else begin
        seq_code[seq_len] = b.code;
        seq_len++;
        seq_occ[b.code] = seq_occ[b.code] + 1'b1;
      end
      return;
    end
    decode_cnt++;
    n = effective_n(nv_now[NV_W-1:0]);
    m = n - 2;
    bad = seq_err || (seq_len != m);
    for (int i = 0; i < seq_len; i++)
      if (seq_code[i] >= n) bad = 1'b1;
    if (bad) begin
      e = '{leaf_vertex: '0, joined_vertex: '0, last_edge: 1'b1, bad_sequence: 1'b1};
      edge_queue = {edge_queue, e};
      reject_cnt++;
      clear_sequence();
      return;
    end
    // initial leaves: vertices that never occur in the sequence
    leaves = '0;
    for (int i = 0; i < n; i++)
      if (seq_occ[i] == 0) leaves[i] = 1'b1;
    for (int i = 0; i < m; i++) begin
      v = seq_code[i];
      u = lowest_leaf(leaves);
      leaves[u] = 1'b0;
      e = '{leaf_vertex: u, joined_vertex: v, last_edge: 1'b0, bad_sequence: 1'b0};
      edge_queue = {edge_queue, e};
      seq_occ[v] = seq_occ[v] - 1'b1;
      if (seq_occ[v] == 0) leaves[v] = 1'b1;
    end
    // closing edge between the two remaining leaves
    u = lowest_leaf(leaves);
    leaves[u] = 1'b0;
    w = lowest_leaf(leaves);
    e = '{leaf_vertex: u, joined_vertex: w, last_edge: 1'b1, bad_sequence: 1'b0};
    edge_queue = {edge_queue, e};
    clear_sequence();
  endtask

  task automatic check_field(input string name, input logic [VERT_W-1:0] got,
                             input logic [VERT_W-1:0] want);
    if (got !== want)
      note_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Input driver: new beats and gaps at the falling edge
  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      // a gap is drawn once the previous beat has been taken
      gap = in_gap;
      if (in_fired) begin
        gap = draw_wait(in_calm);
        if ($urandom_range(0, 29) == 0) in_calm <= !in_calm;
      end
      if (gap > 0) begin
        push   <= 1'b0;
        in_gap <= gap - 1;
      end else if (push && !in_fired) begin
        // beat still waiting for acceptance
      end else if (beat_queue.size() > 0) begin
        in_data <= beat_queue.pop_front();
        push    <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: pop stalls at the falling edge
  always @(negedge clk) begin
    int stall;
    stall = out_stall;
    if (out_fired) begin
      stall = draw_wait(out_calm);
      if ($urandom_range(0, 29) == 0) out_calm <= !out_calm;
    end
    if (rst_n && stall > 0) begin
      pop       <= 1'b0;
      out_stall <= stall - 1;
    end else begin
      pop <= rst_n;
    end
  end

  // Monitor: accepted beats on both channels at the rising edge
  always @(posedge clk) begin
    out_beat_t want;
    in_fired  <= rst_n && push && !full;
    out_fired <= rst_n && pop && !empty;
    if (rst_n && push && !full) begin
      decode_beat(in_data);
      accepted_cnt++;
    end
    if (rst_n && pop && !empty) begin
      edge_cnt++;
      if (edge_queue.size() == 0) begin
        note_error($sformatf("unexpected result beat: leaf %0d joined %0d last %0b bad %0b",
                             out_data.leaf_vertex, out_data.joined_vertex,
                             out_data.last_edge, out_data.bad_sequence));
      end else begin
        want = edge_queue.pop_front();
        check_field("leaf_vertex", out_data.leaf_vertex, want.leaf_vertex);
        check_field("joined_vertex", out_data.joined_vertex, want.joined_vertex);
        check_field("last_edge", VERT_W'(out_data.last_edge), VERT_W'(want.last_edge));
        check_field("bad_sequence", VERT_W'(out_data.bad_sequence),
                    VERT_W'(want.bad_sequence));
      end
    end
  end

  // Watchdog: too long without any beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic queue_load(input int code);
    in_beat_t b;
    b.kind = KIND_LOAD;
    b.code = code[VERT_W-1:0];
    beat_queue = {beat_queue, b};
    queued_cnt++;
  endtask

  task automatic queue_decode();
    in_beat_t b;
    b.kind = KIND_DECODE;
    b.code = VERT_W'($urandom_range(0, 31));
    beat_queue = {beat_queue, b};
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || edge_queue.size() != 0) @(negedge clk);
  endtask

  // Register write only with the block idle
  task automatic write_vertex_count(input logic [NV_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    nv_now     = int'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_cnt++;
  endtask

  // One sequence followed by its decode: mostly well formed, some broken
  task automatic queue_sequence(input int n);
    int m;
    int sel;
    int cnt;
    int pos;
    m = n - 2;
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      for (int i = 0; i < m; i++) queue_load($urandom_range(0, n - 1));
    end else if (sel == 7) begin
      // wrong length, sometimes overflowing the store
      if ($urandom_range(0, 2) == 0) cnt = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
      else if (m > 0 && $urandom_range(0, 1) == 1) cnt = m - 1;
      else cnt = m + 1;
      for (int i = 0; i < cnt; i++) queue_load($urandom_range(0, n - 1));
    end else if (sel == 8 && n < MAX_VERTICES_DEF && m > 0) begin
      // right length, one label beyond the vertex count
      pos = $urandom_range(0, m - 1);
      for (int i = 0; i < m; i++)
        queue_load(i == pos ? $urandom_range(n, 31) : $urandom_range(0, n - 1));
    end else begin
      cnt = $urandom_range(0, 8);
      for (int i = 0; i < cnt; i++) queue_load($urandom_range(0, 31));
    end
    queue_decode();
  endtask

  // Stimulus
  initial begin
    int               ph;
    int               pick;
    int               nseq;
    logic [NV_W-1:0]  nv;
    clear_sequence();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default 32 vertices: empty sequence, then a short one
    queue_decode();
    queue_load(31);
    queue_decode();
    // register 0 acts as two vertices: single edge, then a stray code
    write_vertex_count(6'd0);
    queue_decode();
    queue_load(0);
    queue_decode();
    write_vertex_count(6'd1);
    queue_decode();
    // star on four vertices, then a label out of range
    write_vertex_count(6'd4);
    queue_load(3);
    queue_load(3);
    queue_decode();
    queue_load(2);
    queue_load(4);
    queue_decode();
    // path on five vertices
    write_vertex_count(6'd5);
    queue_load(1);
    queue_load(2);
    queue_load(3);
    queue_decode();

    // random phases, each at one vertex count
    ph = 0;
    while (queued_cnt < TARGET_BEATS) begin
      if (ph == 0) begin
        nv = 6'd63;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 5))
            0: nv = 6'd0;
            1: nv = 6'd1;
            2: nv = 6'd2;
            3: nv = 6'd32;
            4: nv = 6'd33;
            default: nv = 6'd63;
          endcase
        end else if (pick == 1) begin
          nv = NV_W'($urandom_range(0, 63));
        end else begin
          nv = NV_W'($urandom_range(3, 10));
        end
      end
      write_vertex_count(nv);
      nseq = $urandom_range(2, 5);
      for (int s = 0; s < nseq && queued_cnt < TARGET_BEATS; s++)
        queue_sequence(effective_n(nv));
      ph++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d load and %0d decode beats (%0d rejected), %0d edges checked,",
             load_cnt, decode_cnt, reject_cnt, edge_cnt);
    $display("over %0d vertex-count writes including the clamped extremes.", cfg_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
